[rtl/lsq_pkg.sv]
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared constants, types and helper functions for the largest square block.
// ----------------------------------------------------------------------------
package lsq_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int LEN_W       = 11;
    localparam int SIDE_W      = 11;
    localparam int CMP_W       = (LEN_W > COL_W + 1) ? LEN_W : COL_W + 1;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [CMP_W-1:0]  cmp_t;

    localparam len_t  ROW_LENGTH_RESET = LEN_W'(1024);
    localparam side_t SIDE_MAX         = '1;
    localparam col_t  LAST_ENTRY       = COL_W'(MAX_COLUMNS - 1);

    // item moving from the address stage into the update stage
    typedef struct packed {
        logic valid;
        logic filled;
        logic last;
        col_t col;
        logic first;
        logic fwd;
    } lsq_stage_t;

    typedef struct packed {
        logic  valid;
        side_t best;
    } lsq_result_t;

    function automatic cmp_t effective_length(len_t row_length);
        cmp_t ext;
        ext = CMP_W'(row_length);
        if (ext == '0)
            return CMP_W'(1);
        else if (ext > CMP_W'(MAX_COLUMNS))
            return CMP_W'(MAX_COLUMNS);
        else
            return ext;
    endfunction

    function automatic side_t min3(side_t a, side_t b, side_t c);
        side_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

[rtl/lsq_if.sv]
// ----------------------------------------------------------------------------
// lsq_if
// Valid/ready channel interfaces for cells, results and configuration.
// ----------------------------------------------------------------------------
interface lsq_in_if;
    logic valid;
    logic ready;
    logic cell_req;
    logic last_cell;

    modport source (output valid, output cell_req, output last_cell, input ready);
    modport sink   (input valid, input cell_req, input last_cell, output ready);
endinterface

interface lsq_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] best_side;

    modport source (output valid, output best_side, input ready);
    modport sink   (input valid, input best_side, output ready);
endinterface

interface lsq_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] row_length;

    modport source (output valid, output row_length, input ready);
    modport sink   (input valid, input row_length, output ready);
endinterface

[rtl/lsq_ram.sv]
// ----------------------------------------------------------------------------
// lsq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lsq_ctrl.sv]
// ----------------------------------------------------------------------------
// lsq_ctrl
// Row length register, line buffer clearing pass, column tracking and the
// address stage that issues the line buffer read.
// ----------------------------------------------------------------------------
module lsq_ctrl import lsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lsq_cfg_if.sink     cfg,
    lsq_in_if.sink      cells,
    input  logic        space_ok,
    output lsq_stage_t  stage,
    output col_t        rd_addr,
    output logic        clearing,
    output col_t        clr_addr
);

    len_t       row_length_reg;
    col_t       col_reg;
    col_t       col_next;
    logic       first_reg;
    logic       first_next;
    lsq_stage_t stage_reg;
    lsq_stage_t stage_next;
    logic       clearing_reg;
    col_t       clr_cnt_reg;
    logic       accept;
    logic       wrap;

    assign cfg.ready   = 1'b1;
    assign cells.ready = !clearing_reg && space_ok;
    assign accept      = cells.valid && cells.ready;

    assign wrap = (CMP_W'(col_reg) + CMP_W'(1)) >= effective_length(row_length_reg);

    always_comb
    begin
        col_next   = col_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (wrap)
            begin
                col_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            if (cells.last_cell)
            begin
                col_next   = '0;
                first_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        stage_next.valid  = accept;
        stage_next.filled = cells.cell_req;
        stage_next.last   = cells.last_cell;
        stage_next.col    = col_reg;
        stage_next.first  = first_reg;
        // previous item writes this column in the cycle of our read
        stage_next.fwd    = stage_reg.valid && (stage_reg.col == col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
            col_reg        <= '0;
            first_reg      <= 1'b1;
            stage_reg      <= '0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                row_length_reg <= cfg.row_length;
            end
            col_reg   <= col_next;
            first_reg <= first_next;
            stage_reg <= stage_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    assign stage    = stage_reg;
    assign rd_addr  = col_reg;
    assign clearing = clearing_reg;
    assign clr_addr = clr_cnt_reg;

endmodule

[rtl/lsq_side.sv]
// ----------------------------------------------------------------------------
// lsq_side
// Update stage: square side from the three neighbors, line buffer write back
// and running maximum per matrix.
// ----------------------------------------------------------------------------
module lsq_side import lsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lsq_stage_t  stage,
    input  side_t       rd_data,
    output logic        wr_en,
    output col_t        wr_addr,
    output side_t       wr_data,
    output lsq_result_t push
);

    side_t               left_reg;
    side_t               ul_reg;
    side_t               best_reg;
    side_t               up;
    side_t               left;
    side_t               diag;
    logic [SIDE_W:0]     sum;
    side_t               side;
    side_t               best_next;

    always_comb
    begin
        if (stage.first)
            up = '0;
        else if (stage.fwd)
            up = left_reg;
        else
            up = rd_data;
        left = (stage.col == '0) ? '0 : left_reg;
        diag = ((stage.col == '0) || stage.first) ? '0 : ul_reg;
        sum  = {1'b0, min3(up, left, diag)} + (SIDE_W + 1)'(1);
        if (!stage.filled)
            side = '0;
        else if (sum[SIDE_W])
            side = SIDE_MAX;
        else
            side = sum[SIDE_W-1:0];
        best_next = (side > best_reg) ? side : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
            best_reg <= '0;
        end
        else if (stage.valid)
        begin
            left_reg <= side;
            ul_reg   <= up;
            best_reg <= stage.last ? '0 : best_next;
        end
    end

    assign wr_en      = stage.valid;
    assign wr_addr    = stage.col;
    assign wr_data    = side;
    assign push.valid = stage.valid && stage.last;
    assign push.best  = best_next;

endmodule

[rtl/lsq_outbuf.sv]
// ----------------------------------------------------------------------------
// lsq_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module lsq_outbuf import lsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lsq_result_t push,
    lsq_out_if.source   result,
    output logic        space_ok
);

    logic  out_valid_reg;
    side_t out_data_reg;
    logic  skid_valid_reg;
    side_t skid_data_reg;
    logic  pop;

    assign pop = out_valid_reg && result.ready;

    // room for one more transfer landing next cycle
    assign space_ok = !skid_valid_reg && !(out_valid_reg && push.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (push.valid)
                begin
                    skid_data_reg <= push.best;
                end
                else
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push.valid)
            begin
                out_data_reg <= push.best;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (!out_valid_reg)
            begin
                out_data_reg  <= push.best;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_data_reg  <= push.best;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.best_side = out_data_reg;

endmodule

[rtl/largest_square_of_ones.sv]
// ----------------------------------------------------------------------------
// largest_square_of_ones
// Largest all-ones square in a binary matrix streamed one cell per transfer.
// ----------------------------------------------------------------------------
// Cells arrive in row-major order, row_length cells to a row; the cell marked
// last closes the matrix and yields one transfer with the side of the largest
// all-ones square. The block takes one cell per clock while cells are not held
// off: a two-stage pipeline around a line buffer RAM that is read and written
// once per cycle, with forwarding when consecutive cells hit the same column.
// Each cell's side is worked out in the cycle after its transfer, and the
// result of the last cell is registered into the output buffer. Results wait
// in a two-entry buffer; cells are held off while that buffer cannot take
// another result. After reset the line buffer is cleared, all MAX_COLUMNS (1024)
// entries, and no cell is taken until that is done; row_length writes are taken at any time.
module largest_square_of_ones import lsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lsq_cfg_if.sink    cfg,
    lsq_in_if.sink     cells,
    lsq_out_if.source  result
);

    lsq_stage_t  stage;
    lsq_result_t push;
    col_t        rd_addr;
    side_t       rd_data;
    logic        clearing;
    col_t        clr_addr;
    logic        side_wr_en;
    col_t        side_wr_addr;
    side_t       side_wr_data;
    logic        ram_we;
    col_t        ram_waddr;
    side_t       ram_wdata;
    logic        space_ok;

    lsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cells    (cells),
        .space_ok (space_ok),
        .stage    (stage),
        .rd_addr  (rd_addr),
        .clearing (clearing),
        .clr_addr (clr_addr)
    );

    // clearing pass owns the write port until it is done
    assign ram_we    = clearing || side_wr_en;
    assign ram_waddr = clearing ? clr_addr : side_wr_addr;
    assign ram_wdata = clearing ? '0 : side_wr_data;

    lsq_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lsq_side u_side (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .rd_data (rd_data),
        .wr_en   (side_wr_en),
        .wr_addr (side_wr_addr),
        .wr_data (side_wr_data),
        .push    (push)
    );

    lsq_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .result   (result),
        .space_ok (space_ok)
    );

    // no cell taken while the line buffer is being cleared
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !cells.ready)
        else $error("cell taken during clearing pass");

    // an accepted cell reaches the update stage at the column it was read
    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cells.valid && cells.ready) |=> (stage.valid && stage.col == $past(rd_addr)))
        else $error("accepted cell missing from update stage");

    // forwarding only from a valid item on the same column
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && stage.fwd) |-> ($past(stage.valid) && $past(stage.col) == stage.col))
        else $error("forwarding without a matching write");

endmodule
